>>> rtl/core/pnf_pkg.sv
// Shared types, constants and helpers of the padded number formatter.
package pnf_pkg;

    localparam int MAX_DIGITS      = 22;
    localparam int MAX_FIELD_WIDTH = 62;
    localparam int VALUE_BITS      = 64;
    localparam int BCD_DIGITS      = (MAX_DIGITS < 20) ? MAX_DIGITS : 20;
    localparam int DIG_IDX_W       = $clog2(MAX_DIGITS);
    localparam int CNT_W           = $clog2(MAX_DIGITS + 1);
    localparam int POS_W           = $clog2(MAX_FIELD_WIDTH + 3);
    localparam int STEP_W          = $clog2(VALUE_BITS);

    localparam logic [2:0] CONV_SDEC = 3'd0;
    localparam logic [2:0] CONV_UDEC = 3'd1;
    localparam logic [2:0] CONV_OCT  = 3'd2;
    localparam logic [2:0] CONV_HEXL = 3'd3;
    localparam logic [2:0] CONV_HEXU = 3'd4;
    localparam logic [2:0] CONV_CHAR = 3'd5;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_X_LOW  = 8'h78;
    localparam logic [7:0] CH_X_UP   = 8'h58;
    localparam logic [7:0] HEX_GAP   = 8'h07;
    localparam logic [7:0] LOWER_OFS = 8'h20;

    typedef struct packed {
        logic [2:0]  conversion;
        logic [63:0] value;
        logic        wide;
        logic [5:0]  field_width;
        logic        left_justify;
        logic        zero_pad;
        logic        alternate;
    } t_in;

    typedef struct packed {
        logic [7:0] character;
        logic       last;
    } t_out;

    typedef struct packed {
        logic [2:0]  conversion;
        logic        minus;
        logic [63:0] mag;
        logic [5:0]  width;
        logic        left;
        logic        zpad;
        logic        alt;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] c;
        c = CH_ZERO + {4'b0, d};
        if (d > 4'd9) begin
            c = c + HEX_GAP + (upper ? 8'h00 : LOWER_OFS);
        end
        return c;
    endfunction

endpackage

>>> rtl/core/padded_number_formatter.sv
// Top level of the padded number formatter: front end, job queue and formatting engine.
// Each accepted request yields its characters one per transaction, the final one marked
// with last; requests with an unused conversion code are accepted and yield nothing.
// The front end queues up to two requests while the engine works. The engine takes a
// job from the queue, runs shift-and-add-3 conversion for decimal kinds (none for
// octal, hex or character), scans the digit register for leading zeros (none for
// character) and sets up the field, then emits one character per cycle (1 to 64
// characters), slower while the output register waits on its handshake.
module padded_number_formatter (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  pnf_pkg::t_in  i_item,
    output logic          o_valid,
    input  logic          i_ready,
    output pnf_pkg::t_out o_item
);

    pnf_pkg::t_job    front_job;
    pnf_pkg::t_job    queue_job;
    pnf_pkg::t_q_stat q_stat;
    logic             push;
    logic             pop;

    pnf_front u_front (
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_item   (i_item),
        .i_q_stat (q_stat),
        .o_push   (push),
        .o_job    (front_job)
    );

    pnf_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_job    (front_job),
        .i_pop    (pop),
        .o_job    (queue_job),
        .o_q_stat (q_stat)
    );

    pnf_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_stat (q_stat),
        .i_job    (queue_job),
        .o_pop    (pop),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_item   (o_item)
    );

    a_q_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("queue full and empty together");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_stat.empty)
        else $error("pop from empty queue");

    a_drop_unused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && (i_item.conversion > pnf_pkg::CONV_CHAR)) |-> !push)
        else $error("unused conversion code queued");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop && q_stat.empty) |=> !q_stat.empty)
        else $error("queued transaction lost");

endmodule

>>> rtl/core/pnf_front.sv
// Front end: accepts requests, drops unused codes, forms sign and magnitude.
module pnf_front (
    input  logic             i_valid,
    output logic             o_ready,
    input  pnf_pkg::t_in     i_item,
    input  pnf_pkg::t_q_stat i_q_stat,
    output logic             o_push,
    output pnf_pkg::t_job    o_job
);

    logic [31:0] v32;
    logic [31:0] neg32;

    assign o_ready = !i_q_stat.full;
    assign o_push  = i_valid && o_ready && (i_item.conversion <= pnf_pkg::CONV_CHAR);
    assign v32     = i_item.value[31:0];
    assign neg32   = 32'd0 - v32;

    always_comb begin
        o_job.conversion = i_item.conversion;
        o_job.left       = i_item.left_justify;
        o_job.zpad       = i_item.zero_pad;
        o_job.alt        = i_item.alternate;
        o_job.width      = (i_item.field_width > 6'(pnf_pkg::MAX_FIELD_WIDTH))
                         ? 6'(pnf_pkg::MAX_FIELD_WIDTH) : i_item.field_width;
        o_job.minus      = 1'b0;
        o_job.mag        = i_item.wide ? i_item.value : {32'd0, v32};
        if (i_item.conversion == pnf_pkg::CONV_SDEC) begin
            if (i_item.wide) begin
                o_job.minus = i_item.value[63];
                o_job.mag   = i_item.value[63] ? (64'd0 - i_item.value) : i_item.value;
            end else begin
                o_job.minus = v32[31];
                o_job.mag   = {32'd0, v32[31] ? neg32 : v32};
            end
        end else if (i_item.conversion == pnf_pkg::CONV_CHAR) begin
            o_job.mag = {56'd0, i_item.value[7:0]};
        end
    end

endmodule

>>> rtl/core/pnf_queue.sv
// Two-entry job queue between the front end and the formatting engine.
module pnf_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  pnf_pkg::t_job    i_job,
    input  logic             i_pop,
    output pnf_pkg::t_job    o_job,
    output pnf_pkg::t_q_stat o_q_stat
);

    pnf_pkg::t_job r_mem [2];
    logic          r_wptr;
    logic          r_rptr;
    logic [1:0]    r_count;
    logic          n_wptr;
    logic          n_rptr;
    logic [1:0]    n_count;

    assign o_job          = r_mem[r_rptr];
    assign o_q_stat.full  = (r_count == 2'd2);
    assign o_q_stat.empty = (r_count == 2'd0);

    always_comb begin
        n_wptr  = i_push ? !r_wptr : r_wptr;
        n_rptr  = i_pop ? !r_rptr : r_rptr;
        n_count = r_count + {1'b0, i_push} - {1'b0, i_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

endmodule

>>> rtl/core/pnf_back.sv
// Formatting engine: digit conversion, digit count scan and character emission.
module pnf_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  pnf_pkg::t_q_stat i_q_stat,
    input  pnf_pkg::t_job    i_job,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output pnf_pkg::t_out    o_item
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CONV  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_SETUP = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;

    localparam int PW = pnf_pkg::POS_W;

    logic [2:0]                    r_state, n_state;
    pnf_pkg::t_job                 r_job, n_job;
    logic [63:0]                   r_shift, n_shift;
    logic [3:0]                    r_dig [pnf_pkg::MAX_DIGITS];
    logic [3:0]                    n_dig [pnf_pkg::MAX_DIGITS];
    logic [pnf_pkg::CNT_W-1:0]     r_ndig, n_ndig;
    logic [pnf_pkg::STEP_W-1:0]    r_cnt, n_cnt;
    logic [PW-1:0]                 r_b1, r_b2, r_b3, r_b4, r_total;
    logic [PW-1:0]                 n_b1, n_b2, n_b3, n_b4, n_total;
    logic [PW-1:0]                 r_pos, n_pos;
    logic                          r_out_valid, n_out_valid;
    pnf_pkg::t_out                 r_out, n_out;

    logic [3:0]                    adj [pnf_pkg::BCD_DIGITS];
    logic [pnf_pkg::MAX_DIGITS*3-1:0] oct_ext;
    logic [pnf_pkg::MAX_DIGITS*4-1:0] hex_ext;
    logic [pnf_pkg::DIG_IDX_W-1:0] scan_idx;
    logic [pnf_pkg::DIG_IDX_W-1:0] emit_idx;
    logic                          is_char, is_sdec, upper, out_free;
    logic [PW-1:0]                 ndig7, len7, width7, pad7, head7, pada7, mid7, padb7;
    logic [7:0]                    padch, head0, head1, emit_ch;
    logic                          emit_last;

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

    assign is_char  = (r_job.conversion == pnf_pkg::CONV_CHAR);
    assign is_sdec  = (r_job.conversion == pnf_pkg::CONV_SDEC);
    assign upper    = (r_job.conversion == pnf_pkg::CONV_HEXU);
    assign out_free = !r_out_valid || i_ready;
    assign oct_ext  = (pnf_pkg::MAX_DIGITS*3)'(i_job.mag);
    assign hex_ext  = (pnf_pkg::MAX_DIGITS*4)'(i_job.mag);
    assign scan_idx = pnf_pkg::DIG_IDX_W'(r_ndig - pnf_pkg::CNT_W'(1));
    assign emit_idx = pnf_pkg::DIG_IDX_W'(r_b4 - r_pos - PW'(1));

    always_comb begin
        for (int i = 0; i < pnf_pkg::BCD_DIGITS; i++) begin
            adj[i] = (r_dig[i] >= 4'd5) ? (r_dig[i] + 4'd3) : r_dig[i];
        end
    end

    always_comb begin
        ndig7  = is_char ? PW'(1) : PW'(r_ndig);
        len7   = ndig7 + PW'(is_sdec & r_job.minus);
        width7 = PW'(r_job.width);
        pad7   = (width7 > len7) ? (width7 - len7) : '0;
        head7  = '0;
        if (is_sdec) begin
            head7 = PW'((r_job.left | r_job.zpad) & r_job.minus);
        end else if (r_job.alt && r_job.conversion == pnf_pkg::CONV_OCT) begin
            head7 = PW'(1);
        end else if (r_job.alt && (r_job.conversion == pnf_pkg::CONV_HEXL ||
                                   r_job.conversion == pnf_pkg::CONV_HEXU)) begin
            head7 = PW'(2);
        end
        pada7 = r_job.left ? '0 : pad7;
        mid7  = PW'(is_sdec & !r_job.left & !r_job.zpad & r_job.minus);
        padb7 = r_job.left ? pad7 : '0;
        padch = (!r_job.left && r_job.zpad && !is_char) ? pnf_pkg::CH_ZERO
                                                         : pnf_pkg::CH_SPACE;
        head0 = is_sdec ? pnf_pkg::CH_MINUS : pnf_pkg::CH_ZERO;
        head1 = upper ? pnf_pkg::CH_X_UP : pnf_pkg::CH_X_LOW;
    end

    always_comb begin
        priority if (r_pos < r_b1) begin
            emit_ch = (r_pos == '0) ? head0 : head1;
        end else if (r_pos < r_b2) begin
            emit_ch = padch;
        end else if (r_pos < r_b3) begin
            emit_ch = pnf_pkg::CH_MINUS;
        end else if (r_pos < r_b4) begin
            emit_ch = is_char ? r_job.mag[7:0] : pnf_pkg::digit_char(r_dig[emit_idx], upper);
        end else begin
            emit_ch = pnf_pkg::CH_SPACE;
        end
        emit_last = (r_pos == r_total - PW'(1));
    end

    always_comb begin
        n_state     = r_state;
        n_job       = r_job;
        n_shift     = r_shift;
        n_dig       = r_dig;
        n_ndig      = r_ndig;
        n_cnt       = r_cnt;
        n_b1        = r_b1;
        n_b2        = r_b2;
        n_b3        = r_b3;
        n_b4        = r_b4;
        n_total     = r_total;
        n_pos       = r_pos;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        o_pop       = 1'b0;
        if (i_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (!i_q_stat.empty) begin
                    o_pop   = 1'b1;
                    n_job   = i_job;
                    n_shift = i_job.mag;
                    n_ndig  = pnf_pkg::CNT_W'(pnf_pkg::MAX_DIGITS);
                    n_cnt   = '1;
                    for (int i = 0; i < pnf_pkg::MAX_DIGITS; i++) begin
                        n_dig[i] = 4'd0;
                    end
                    priority if (i_job.conversion == pnf_pkg::CONV_CHAR) begin
                        n_state = S_SETUP;
                    end else if (i_job.conversion == pnf_pkg::CONV_OCT) begin
                        for (int i = 0; i < pnf_pkg::MAX_DIGITS; i++) begin
                            n_dig[i] = {1'b0, oct_ext[3*i +: 3]};
                        end
                        n_state = S_SCAN;
                    end else if (i_job.conversion == pnf_pkg::CONV_HEXL ||
                                 i_job.conversion == pnf_pkg::CONV_HEXU) begin
                        for (int i = 0; i < pnf_pkg::MAX_DIGITS; i++) begin
                            n_dig[i] = hex_ext[4*i +: 4];
                        end
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_CONV;
                    end
                end
            end
            S_CONV: begin
                n_dig[0] = {adj[0][2:0], r_shift[63]};
                for (int i = 1; i < pnf_pkg::BCD_DIGITS; i++) begin
                    n_dig[i] = {adj[i][2:0], adj[i-1][3]};
                end
                n_shift = {r_shift[62:0], 1'b0};
                if (r_cnt == '0) begin
                    n_state = S_SCAN;
                end else begin
                    n_cnt = r_cnt - pnf_pkg::STEP_W'(1);
                end
            end
            S_SCAN: begin
                if (r_ndig > pnf_pkg::CNT_W'(1) && r_dig[scan_idx] == 4'd0) begin
                    n_ndig = r_ndig - pnf_pkg::CNT_W'(1);
                end else begin
                    n_state = S_SETUP;
                end
            end
            S_SETUP: begin
                n_b1    = head7;
                n_b2    = head7 + pada7;
                n_b3    = head7 + pada7 + mid7;
                n_b4    = head7 + pada7 + mid7 + ndig7;
                n_total = head7 + pada7 + mid7 + ndig7 + padb7;
                n_pos   = '0;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out.character = emit_ch;
                    n_out.last      = emit_last;
                    n_out_valid     = 1'b1;
                    n_pos           = r_pos + PW'(1);
                    if (emit_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_ndig      <= '0;
            r_pos       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_ndig      <= n_ndig;
            r_pos       <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job   <= n_job;
        r_shift <= n_shift;
        r_dig   <= n_dig;
        r_cnt   <= n_cnt;
        r_b1    <= n_b1;
        r_b2    <= n_b2;
        r_b3    <= n_b3;
        r_b4    <= n_b4;
        r_total <= n_total;
        r_out   <= n_out;
    end

endmodule
